>>> rtl/lrcfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED ring clock renderer package
// Shared types, codes and the rainbow color wheel, which is built at
// elaboration from a fixed-point sine rotation.
// ----------------------------------------------------------------------------
package lrcfr_pkg;

	// Ring geometry and fixed colors.
	localparam int RING_LEDS = 60;
	localparam int WHEEL_LEN = 121;
	localparam int SINE_LEN  = 161;
	localparam logic [5:0] PHASE_TOP = 6'd62;

	localparam logic [23:0] COLOR_MARKER        = 24'hd86c00;
	localparam logic [23:0] COLOR_MARKER_SILENT = 24'h646400;
	localparam logic [23:0] COLOR_MINUTE        = 24'h002000;
	localparam logic [23:0] COLOR_MINUTE_SILENT = 24'h006400;
	localparam logic [23:0] COLOR_HOUR          = 24'hf00000;
	localparam logic [23:0] COLOR_HOUR_SILENT   = 24'h640000;

	// Display modes.
	localparam logic [1:0] MODE_STATIC = 2'd0;
	localparam logic [1:0] MODE_ROTATE = 2'd1;
	localparam logic [1:0] MODE_SILENT = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_LED_OFFSET    = 3'd0;
	localparam logic [2:0] CFG_EVENING_START = 3'd1;
	localparam logic [2:0] CFG_NIGHT_START   = 3'd2;
	localparam logic [2:0] CFG_DAY_START     = 3'd3;
	localparam logic [2:0] CFG_DAY_BRIGHT    = 3'd4;
	localparam logic [2:0] CFG_EVENING_BRIGHT = 3'd5;
	localparam logic [2:0] CFG_MODE_WHEN_ON  = 3'd6;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Per-frame drawing context handed to the pixel unit.
	typedef struct packed {
		logic [5:0] offm;        // twelve o'clock position, reduced mod 60
		logic [5:0] minute;      // minute, 0..59
		logic [5:0] hour_pos;    // five times the 12-hour value
		logic [5:0] phase;       // rainbow phase after this update
		logic [1:0] draw_mode;   // mode of the previous update
		logic [8:0] bright;      // dimming factor in 1/256 units
		logic       silent_dim;  // channels reduce to 0 or 1
	} frame_ctx_t;

	typedef logic [23:0] wheel_t [WHEEL_LEN];

	localparam longint Q_ONE = 64'sd1 <<< 60;

	// Taylor terms of sin(0.1), each one truncated from the one before.
	localparam longint SIN_TERM0 = Q_ONE / 10;
	localparam longint SIN_TERM1 = SIN_TERM0 / 600;
	localparam longint SIN_TERM2 = SIN_TERM1 / 2000;
	localparam longint SIN_TERM3 = SIN_TERM2 / 4200;
	localparam longint SIN_TERM4 = SIN_TERM3 / 7200;
	localparam longint SIN_TERM5 = SIN_TERM4 / 11000;
	localparam longint SIN_TERM6 = SIN_TERM5 / 15600;
	localparam longint SIN_TERM7 = SIN_TERM6 / 21000;
	localparam longint SIN_TERM8 = SIN_TERM7 / 27200;
	localparam longint SIN_TENTH = SIN_TERM0 - SIN_TERM1 + SIN_TERM2 - SIN_TERM3 +
		SIN_TERM4 - SIN_TERM5 + SIN_TERM6 - SIN_TERM7 + SIN_TERM8;

	// Taylor terms of cos(0.1), each one truncated from the one before.
	localparam longint COS_TERM1 = Q_ONE / 200;
	localparam longint COS_TERM2 = COS_TERM1 / 1200;
	localparam longint COS_TERM3 = COS_TERM2 / 3000;
	localparam longint COS_TERM4 = COS_TERM3 / 5600;
	localparam longint COS_TERM5 = COS_TERM4 / 9000;
	localparam longint COS_TERM6 = COS_TERM5 / 13200;
	localparam longint COS_TERM7 = COS_TERM6 / 18200;
	localparam longint COS_TERM8 = COS_TERM7 / 24000;
	localparam longint COS_TENTH = Q_ONE - COS_TERM1 + COS_TERM2 - COS_TERM3 +
		COS_TERM4 - COS_TERM5 + COS_TERM6 - COS_TERM7 + COS_TERM8;

	// Remainder by five of a six-bit value through a reciprocal multiply.
	function automatic logic [2:0] mod5_6b(input logic [5:0] x);
		logic [15:0] prod;
		logic [5:0]  q;
		logic [5:0]  r;
		prod = 16'(x) * 16'd205;
		q = prod[15:10];
		r = x - 6'(q * 6'd5);
		return r[2:0];
	endfunction

	// Unsigned Q60 product, truncated.
	function automatic logic [63:0] umul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = 128'(a) * 128'(b);
		return prod[123:60];
	endfunction

	// Signed Q60 product, truncated toward zero.
	function automatic longint smul_q60(input longint a, input longint b);
		logic        neg;
		logic [63:0] ma;
		logic [63:0] mb;
		longint      r;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? 64'(-a) : 64'(a);
		mb = (b < 0) ? 64'(-b) : 64'(b);
		r = longint'(umul_q60(ma, mb));
		return neg ? -r : r;
	endfunction

	// Map a Q60 sine value onto a channel level 1..255.
	function automatic logic [7:0] sine_to_channel(input longint s_in);
		longint      s;
		logic [63:0] p;
		logic [63:0] v;
		s = s_in;
		if (s < -Q_ONE) s = -Q_ONE;
		if (s > Q_ONE) s = Q_ONE;
		p = 64'(s + Q_ONE) >> 4;
		v = 64'd1 + ((64'd127 * p) >> 56);
		return (v > 64'd255) ? 8'd255 : v[7:0];
	endfunction

	// Color wheel: sine rotated in 0.1 rad steps, three phases per entry.
	function automatic wheel_t build_wheel();
		longint sn [SINE_LEN];
		longint s;
		longint c;
		longint ns;
		longint nc;
		int     t;
		wheel_t w;
		s = 0;
		c = Q_ONE;
		sn[0] = 0;
		for (t = 1; t < SINE_LEN; t++) begin
			ns = smul_q60(s, COS_TENTH) + smul_q60(c, SIN_TENTH);
			nc = smul_q60(c, COS_TENTH) - smul_q60(s, SIN_TENTH);
			s = ns;
			c = nc;
			sn[t] = s;
		end
		for (t = 0; t < WHEEL_LEN; t++) begin
			w[t] = {sine_to_channel(sn[t]), sine_to_channel(sn[t + 20]),
				sine_to_channel(sn[t + 40])};
		end
		return w;
	endfunction

	localparam wheel_t WHEEL = build_wheel();

endpackage
`default_nettype wire

>>> rtl/lrcfr_pixel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED ring clock pixel unit
// Works out the color of one ring position from the frame context and dims
// it. The sequencer in the top level runs it once per LED.
// ----------------------------------------------------------------------------
module lrcfr_pixel
	import lrcfr_pkg::*;
(
	input  wire logic [5:0] pos,
	input  frame_ctx_t      ctx,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);

	logic [5:0]  minute_idx;
	logic [6:0]  wheel_idx;
	logic [23:0] rainbow;
	logic [23:0] pixel;
	logic        draw_silent;

	// Dim one channel, or reduce it to a flag at night.
	function automatic logic [7:0] dim(input logic [7:0] c, input logic [8:0] b,
		input logic silent);
		logic [16:0] prod;
		prod = 17'(c) * 17'(b);
		if (silent) return (c != 8'd0) ? 8'd1 : 8'd0;
		return (prod[16] != 1'b0) ? 8'd255 : prod[15:8];
	endfunction

	// Minute index drawn at this position.
	always_comb begin
		if (pos >= ctx.offm) begin
			minute_idx = pos - ctx.offm;
		end else begin
			minute_idx = pos + 6'(RING_LEDS) - ctx.offm;
		end
	end

	// Rainbow color for an elapsed minute.
	always_comb begin
		wheel_idx = 7'(minute_idx) + 7'(ctx.phase);
		case (ctx.draw_mode)
			MODE_STATIC: rainbow = WHEEL[7'(minute_idx)];
			MODE_ROTATE: rainbow = (wheel_idx < 7'(WHEEL_LEN)) ? WHEEL[wheel_idx] : 24'd0;
			default:     rainbow = 24'd0;
		endcase
	end

	// Earlier drawing layers take priority: hour, minute, rainbow, marker.
	always_comb begin
		draw_silent = (ctx.draw_mode == MODE_SILENT);
		if (minute_idx == ctx.hour_pos) begin
			pixel = draw_silent ? COLOR_HOUR_SILENT : COLOR_HOUR;
		end else if (minute_idx == ctx.minute) begin
			pixel = draw_silent ? COLOR_MINUTE_SILENT : COLOR_MINUTE;
		end else if (minute_idx < ctx.minute && mod5_6b(pos) != 3'd0) begin
			pixel = rainbow;
		end else if (mod5_6b(minute_idx) == 3'd0) begin
			pixel = draw_silent ? COLOR_MARKER_SILENT : COLOR_MARKER;
		end else begin
			pixel = 24'd0;
		end
	end

	assign red   = dim(pixel[23:16], ctx.bright, ctx.silent_dim);
	assign green = dim(pixel[15:8], ctx.bright, ctx.silent_dim);
	assign blue  = dim(pixel[7:0], ctx.bright, ctx.silent_dim);

endmodule
`default_nettype wire

>>> rtl/led_ring_clock_frame_renderer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED ring clock frame renderer
// Turns a time update into a 60-LED ring frame with hour markers, rainbow
// minutes and solid minute and hour LEDs, dimmed for day, evening or night.
// ----------------------------------------------------------------------------
// Usage:
// A time update (hour, minute) enters on the s_axis channel. The block then
// emits 60 result transactions on m_axis, ring positions 0 to 59 in order,
// with tlast on position 59. One pixel unit renders and dims one LED per
// cycle while the receiver does not stall; the frame context is registered
// with the input transaction and each result goes through the output
// register. s_axis_tready is low from the input transaction until the cycle
// after the last result is taken, so the block takes no new update before
// the frame is through. When m_axis_tready is low, the current result holds
// and rendering pauses. The frame is drawn with the mode left by the previous
// update and dimmed with the mode of this one.
// Configuration writes on the cfg channel are always taken and must happen
// while the block is idle. Reset clears the sequencer, restores the register
// defaults, sets the rainbow phase to 62 and the mode to rotating rainbow.
// ----------------------------------------------------------------------------
module led_ring_clock_frame_renderer
	import lrcfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Time updates. tdata: hour [7:0], minute [15:8].
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,
	// LED colors. tdata: led_index [5:0], red [13:6], green [21:14],
	// blue [29:22], zero [31:30]. tlast: last_led.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);

	state_t      state_q;
	state_t      state_next;

	logic [5:0]  led_offset_q;
	logic [4:0]  evening_start_q;
	logic [4:0]  night_start_q;
	logic [4:0]  day_start_q;
	logic [8:0]  day_bright_q;
	logic [8:0]  evening_bright_q;
	logic [1:0]  mode_when_on_q;
	logic [5:0]  phase_q;
	logic [1:0]  mode_q;

	frame_ctx_t  ctx_q;
	logic [5:0]  pos_q;
	logic        out_valid_q;
	logic [29:0] out_data_q;
	logic        out_last_q;

	logic        in_accept;
	logic        advance;
	logic        frame_done;

	logic [7:0]  hour_in;
	logic [7:0]  minute_in;
	logic [3:0]  hour12;
	logic [7:0]  hour_less12;
	logic [1:0]  mode_new;
	logic [8:0]  bright_new;
	logic [5:0]  phase_new;

	logic [7:0]  px_red;
	logic [7:0]  px_green;
	logic [7:0]  px_blue;

	assign hour_in    = s_axis_tdata[7:0];
	assign minute_in  = s_axis_tdata[15:8];
	assign in_accept  = s_axis_tvalid && s_axis_tready;
	assign advance    = !out_valid_q || m_axis_tready;
	assign frame_done = (pos_q == 6'(RING_LEDS));
	assign cfg_ready  = 1'b1;

	// Hour folded onto the dial.
	always_comb begin
		hour_less12 = hour_in - 8'd12;
		if (hour_in < 8'd12) begin
			hour12 = hour_in[3:0];
		end else if (hour_less12 < 8'd12) begin
			hour12 = hour_less12[3:0];
		end else begin
			hour12 = 4'd0;
		end
	end

	// Day, evening or night from the raw hour.
	always_comb begin
		if (hour_in >= 8'(evening_start_q) && hour_in < 8'(night_start_q)) begin
			mode_new   = mode_when_on_q;
			bright_new = evening_bright_q;
		end else if (hour_in >= 8'(night_start_q) || hour_in < 8'(day_start_q)) begin
			mode_new   = MODE_SILENT;
			bright_new = 9'd0;
		end else begin
			mode_new   = mode_when_on_q;
			bright_new = day_bright_q;
		end
		phase_new = (phase_q != 6'd0) ? phase_q - 6'd1 : PHASE_TOP;
	end

	// Sequencer: next state and input ready.
	always_comb begin
		state_next    = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_next = ST_RUN;
			end
			ST_RUN: begin
				if (frame_done && advance) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_offset_q     <= 6'd0;
			evening_start_q  <= 5'd19;
			night_start_q    <= 5'd21;
			day_start_q      <= 5'd7;
			day_bright_q     <= 9'd38;
			evening_bright_q <= 9'd18;
			mode_when_on_q   <= MODE_ROTATE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LED_OFFSET:     led_offset_q     <= cfg_data[5:0];
				CFG_EVENING_START:  evening_start_q  <= cfg_data[4:0];
				CFG_NIGHT_START:    night_start_q    <= cfg_data[4:0];
				CFG_DAY_START:      day_start_q      <= cfg_data[4:0];
				CFG_DAY_BRIGHT:     day_bright_q     <= cfg_data;
				CFG_EVENING_BRIGHT: evening_bright_q <= cfg_data;
				CFG_MODE_WHEN_ON: begin
					if (cfg_data[1:0] != 2'd3) mode_when_on_q <= cfg_data[1:0];
				end
				default: ;
			endcase
		end
	end

	// Mode and rainbow phase advance once per update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_TOP;
			mode_q  <= MODE_ROTATE;
		end else if (in_accept) begin
			phase_q <= phase_new;
			mode_q  <= mode_new;
		end
	end

	// Frame context captured with the update; drawing keeps the old mode.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ctx_q.offm       <= (led_offset_q >= 6'(RING_LEDS)) ?
				led_offset_q - 6'(RING_LEDS) : led_offset_q;
			ctx_q.minute     <= (minute_in >= 8'(RING_LEDS)) ? 6'd0 : minute_in[5:0];
			ctx_q.hour_pos   <= 6'(hour12) * 6'd5;
			ctx_q.phase      <= phase_new;
			ctx_q.draw_mode  <= mode_q;
			ctx_q.bright     <= bright_new;
			ctx_q.silent_dim <= (mode_new == MODE_SILENT);
		end
	end

	lrcfr_pixel u_pixel (
		.pos   (pos_q),
		.ctx   (ctx_q),
		.red   (px_red),
		.green (px_green),
		.blue  (px_blue)
	);

	// LED position counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 6'd0;
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			pos_q <= 6'd0;
		end else if (state_q == ST_RUN && advance) begin
			if (!frame_done) begin
				pos_q       <= pos_q + 6'd1;
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register holds the result while the receiver stalls.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && advance && !frame_done) begin
			out_data_q <= {px_blue, px_green, px_red, pos_q};
			out_last_q <= (pos_q == 6'(RING_LEDS - 1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_data_q};
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
